// ===== rtl/look_at_view_matrix_unit_macros.svh =====
// assertion macros for the look-at view matrix unit checker
// expects clk and rst_n in the scope where a macro is used
`ifndef LOOK_AT_VIEW_MATRIX_UNIT_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LAV_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LAV_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lav_pkg.sv =====
// shared constants and types for the look-at view matrix unit
// no dependencies
`default_nettype none

package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 24;
  localparam int ROT_W     = 18;
  localparam int SHIFT_W   = 25;

  // normalizer: magnitudes below 2^NM_W, sum of squares, root, quotient
  localparam int NM_W   = 25;
  localparam int SQ_W   = 2 * NM_W + 2;
  localparam int NR_W   = NM_W + 1;
  localparam int Q_W    = FRAC_BITS + 1;
  localparam int REM_W  = NR_W + 1;
  localparam int NORM_LAT = NR_W + Q_W + 3;

  localparam int CP_W   = IN_W + ROT_W;
  localparam int C_W    = CP_W + 1;
  localparam int SH_W   = $clog2(C_W);
  localparam int FL_W   = 2 * ROT_W;
  localparam int DOT_W  = CP_W + 2;

  localparam int IN_BYTES  = (9 * IN_W + 7) / 8;
  localparam int OUT_BITS  = 9 * ROT_W + 3 * SHIFT_W;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

  localparam logic [Q_W-1:0] QONE = Q_W'(1) << FRAC_BITS;

  typedef logic signed [IN_W-1:0]    coord_t;
  typedef logic signed [ROT_W-1:0]   rot_t;
  typedef logic signed [SHIFT_W-1:0] xlat_t;
  typedef logic [NM_W-1:0]           nmag_t;
  typedef logic [Q_W-1:0]            quot_t;

endpackage

`default_nettype wire

// ===== rtl/lav_norm.sv =====
// pipelined vector normalizer: squares, bit-per-stage square root,
// bit-per-stage restoring divide; uses lav_pkg
`default_nettype none

module lav_norm (
  input  logic            clk,
  input  logic            en,
  input  lav_pkg::nmag_t  mag_i  [3],
  output lav_pkg::quot_t  quot_o [3]
);

  localparam int D_W = lav_pkg::NM_W + lav_pkg::FRAC_BITS + 1;

  logic [2*lav_pkg::NM_W-1:0] sq_r  [3];
  lav_pkg::nmag_t             msq_r [3];

  logic [lav_pkg::SQ_W-1:0]   rad_r  [lav_pkg::NR_W+1];
  logic [lav_pkg::SQ_W-1:0]   root_r [lav_pkg::NR_W+1];
  lav_pkg::nmag_t             mrt_r  [lav_pkg::NR_W+1][3];

  logic [lav_pkg::NR_W-1:0]   den_r [lav_pkg::Q_W+1];
  logic [lav_pkg::REM_W-1:0]  rem_r [lav_pkg::Q_W+1][3];
  lav_pkg::quot_t             lq_r  [lav_pkg::Q_W+1][3];

  logic [D_W-1:0]             dvd   [3];
  logic [lav_pkg::NR_W-1:0]   root_fin;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i]  <= mag_i[i] * mag_i[i];
        msq_r[i] <= mag_i[i];
      end
      rad_r[0]  <= lav_pkg::SQ_W'(sq_r[0]) + lav_pkg::SQ_W'(sq_r[1])
                 + lav_pkg::SQ_W'(sq_r[2]);
      root_r[0] <= '0;
      mrt_r[0]  <= msq_r;
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < lav_pkg::NR_W; k++) begin : g_sqrt
    localparam logic [lav_pkg::SQ_W-1:0] BitK =
      lav_pkg::SQ_W'(1) << (lav_pkg::SQ_W - 2 - 2 * k);
    logic [lav_pkg::SQ_W-1:0] trial;
    assign trial = root_r[k] + BitK;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rad_r[k] >= trial) begin
          rad_r[k+1]  <= rad_r[k] - trial;
          root_r[k+1] <= (root_r[k] >> 1) + BitK;
        end else begin
          rad_r[k+1]  <= rad_r[k];
          root_r[k+1] <= root_r[k] >> 1;
        end
        mrt_r[k+1] <= mrt_r[k];
      end
    end
  end

  // dividend (m << F) + n/2; quotient stays below 2^(F+1)
  assign root_fin = root_r[lav_pkg::NR_W][lav_pkg::NR_W-1:0];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dvd[i] = (D_W'(mrt_r[lav_pkg::NR_W][i]) << lav_pkg::FRAC_BITS)
             + D_W'(root_fin >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= root_fin;
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= lav_pkg::REM_W'(dvd[i] >> lav_pkg::Q_W);
        lq_r[0][i]  <= dvd[i][lav_pkg::Q_W-1:0];
      end
    end
  end

  // one quotient bit per stage; dividend bits shift out as quotient bits shift in
  for (genvar j = 0; j < lav_pkg::Q_W; j++) begin : g_div
    logic [lav_pkg::REM_W-1:0] trial [3];
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        trial[i] = {rem_r[j][i][lav_pkg::REM_W-2:0], lq_r[j][i][lav_pkg::Q_W-1]};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j+1] <= den_r[j];
        for (int i = 0; i < 3; i++) begin
          if (trial[i] >= lav_pkg::REM_W'(den_r[j])) begin
            rem_r[j+1][i] <= trial[i] - lav_pkg::REM_W'(den_r[j]);
            lq_r[j+1][i]  <= {lq_r[j][i][lav_pkg::Q_W-2:0], 1'b1};
          end else begin
            rem_r[j+1][i] <= trial[i];
            lq_r[j+1][i]  <= {lq_r[j][i][lav_pkg::Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quot_o[i] = (lq_r[lav_pkg::Q_W][i] > lav_pkg::QONE) ? lav_pkg::QONE
                                                          : lq_r[lav_pkg::Q_W][i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/look_at_view_matrix_unit.sv =====
// look-at view matrix unit, top level: rotation rows and translation
// from eye, target and up; uses lav_pkg and lav_norm
//
// channel  dir  fields (lowest bits first)
// in_      in   eye_x/y/z, target_x/y/z, up_dir_x/y/z, 24 bits each
// out_     out  side, upward, back (x/y/z, 18 bits), shift_x/y/z (25 bits)
//
// one word per cycle in and out while the output is not stalled; the two normalizers
// have 26 root stages and 17 divide stages each
// one enable stalls the whole pipeline while a result waits at the output
// reset clears the valid bits only; no word is dropped or repeated on stall
`default_nettype none

module look_at_view_matrix_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_dir_x, up_dir_y, up_dir_z
  input  logic [8*lav_pkg::IN_BYTES-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // side_x/y/z, upward_x/y/z, back_x/y/z, shift_x/y/z, zero fill
  output logic [8*lav_pkg::OUT_BYTES-1:0]  out_tdata
);

  localparam int NL    = lav_pkg::NORM_LAT;
  localparam int VLD_N = 2 * NL + 14;
  localparam int DW    = lav_pkg::DOT_W;

  localparam logic signed [DW-1:0] RotHi = DW'(1) << lav_pkg::FRAC_BITS;
  localparam logic signed [DW-1:0] RotLo = -RotHi;
  localparam logic signed [DW-1:0] XlHi  = (DW'(1) << (lav_pkg::SHIFT_W - 1)) - DW'(1);
  localparam logic signed [DW-1:0] XlLo  = -(DW'(1) << (lav_pkg::SHIFT_W - 1));
  localparam logic [DW-1:0]        Half  = DW'(1) << (lav_pkg::FRAC_BITS - 1);

  // round half away from zero by FRAC_BITS
  function automatic logic signed [DW-1:0] rnd(input logic signed [DW-1:0] x);
    logic [DW-1:0] m;
    m = x[DW-1] ? DW'(-x) : DW'(x);
    m = (m + Half) >> lav_pkg::FRAC_BITS;
    return x[DW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic lav_pkg::rot_t uclamp(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] r;
    r = rnd(x);
    if (r > RotHi) r = RotHi;
    else if (r < RotLo) r = RotLo;
    return lav_pkg::ROT_W'(r);
  endfunction

  function automatic lav_pkg::xlat_t xlate(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] r;
    r = -rnd(x);
    if (r > XlHi) r = XlHi;
    else if (r < XlLo) r = XlLo;
    return lav_pkg::SHIFT_W'(r);
  endfunction

  logic en;
  logic [VLD_N-1:0] vld_r;

  assign en        = ~vld_r[VLD_N-1] | out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[VLD_N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[VLD_N-2:0], in_tvalid};
    end
  end

  // ---------------- front: difference and magnitudes
  lav_pkg::coord_t e_in [3], t_in [3], u_in [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_in[i] = in_tdata[i*lav_pkg::IN_W +: lav_pkg::IN_W];
      t_in[i] = in_tdata[(3+i)*lav_pkg::IN_W +: lav_pkg::IN_W];
      u_in[i] = in_tdata[(6+i)*lav_pkg::IN_W +: lav_pkg::IN_W];
    end
  end

  lav_pkg::coord_t e0_r [3], up0_r [3];
  logic signed [lav_pkg::IN_W:0] d0_r [3];
  lav_pkg::coord_t e1_r [3], up1_r [3];
  lav_pkg::nmag_t  m1_r [3];
  logic [2:0]      dneg1_r;
  logic            dz1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e0_r[i]  <= e_in[i];
        up0_r[i] <= u_in[i];
        d0_r[i]  <= (lav_pkg::IN_W+1)'(e_in[i]) - (lav_pkg::IN_W+1)'(t_in[i]);
        e1_r[i]  <= e0_r[i];
        up1_r[i] <= up0_r[i];
        m1_r[i]  <= d0_r[i][lav_pkg::IN_W] ? lav_pkg::NM_W'(-d0_r[i])
                                           : lav_pkg::NM_W'(d0_r[i]);
        dneg1_r[i] <= d0_r[i][lav_pkg::IN_W];
      end
      dz1_r <= (d0_r[0] == '0) && (d0_r[1] == '0) && (d0_r[2] == '0);
    end
  end

  // ---------------- first normalizer: back vector
  lav_pkg::quot_t q1 [3];
  lav_norm u_norm_back (.clk(clk), .en(en), .mag_i(m1_r), .quot_o(q1));

  lav_pkg::coord_t sb1_e_r [NL][3], sb1_up_r [NL][3];
  logic [2:0]      sb1_neg_r [NL];
  logic            sb1_z_r [NL];

  always_ff @(posedge clk) begin
    if (en) begin
      sb1_e_r[0]   <= e1_r;
      sb1_up_r[0]  <= up1_r;
      sb1_neg_r[0] <= dneg1_r;
      sb1_z_r[0]   <= dz1_r;
      for (int k = 1; k < NL; k++) begin
        sb1_e_r[k]   <= sb1_e_r[k-1];
        sb1_up_r[k]  <= sb1_up_r[k-1];
        sb1_neg_r[k] <= sb1_neg_r[k-1];
        sb1_z_r[k]   <= sb1_z_r[k-1];
      end
    end
  end

  // ---------------- cross product up x back, then pre-shift
  lav_pkg::coord_t e2_r [3], up2_r [3], e3_r [3], e4_r [3], e5_r [3], e6_r [3], e7_r [3];
  lav_pkg::rot_t   f2_r [3], f3_r [3], f4_r [3], f5_r [3], f6_r [3], f7_r [3];
  logic            z2_r, z3_r, z4_r, z5_r, z6_r, z7_r;
  logic signed [lav_pkg::CP_W-1:0] p3_r [6];
  logic signed [lav_pkg::C_W-1:0]  c4_r [3];
  logic [lav_pkg::C_W-1:0]         cm5_r [3], cm6_r [3];
  logic [2:0]                      cn5_r, cn6_r, cn7_r;
  logic [lav_pkg::SH_W-1:0]        sh6_r;
  lav_pkg::nmag_t                  m7_r [3];

  logic [lav_pkg::C_W-1:0]  cor;
  logic [lav_pkg::SH_W-1:0] msb_pos, sh_nxt;
  always_comb begin
    cor = cm5_r[0] | cm5_r[1] | cm5_r[2];
    msb_pos = '0;
    for (int b = 0; b < lav_pkg::C_W; b++) begin
      if (cor[b]) msb_pos = lav_pkg::SH_W'(b);
    end
    sh_nxt = (msb_pos >= lav_pkg::SH_W'(lav_pkg::NM_W))
           ? msb_pos - lav_pkg::SH_W'(lav_pkg::NM_W - 1) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        f2_r[i]  <= sb1_neg_r[NL-1][i] ? -lav_pkg::rot_t'(q1[i]) : lav_pkg::rot_t'(q1[i]);
        e2_r[i]  <= sb1_e_r[NL-1][i];
        up2_r[i] <= sb1_up_r[NL-1][i];
      end
      z2_r <= sb1_z_r[NL-1];

      p3_r[0] <= up2_r[1] * f2_r[2];
      p3_r[1] <= up2_r[2] * f2_r[1];
      p3_r[2] <= up2_r[2] * f2_r[0];
      p3_r[3] <= up2_r[0] * f2_r[2];
      p3_r[4] <= up2_r[0] * f2_r[1];
      p3_r[5] <= up2_r[1] * f2_r[0];
      e3_r <= e2_r; f3_r <= f2_r; z3_r <= z2_r;

      for (int i = 0; i < 3; i++) begin
        c4_r[i] <= lav_pkg::C_W'(p3_r[2*i]) - lav_pkg::C_W'(p3_r[2*i+1]);
      end
      e4_r <= e3_r; f4_r <= f3_r; z4_r <= z3_r;

      for (int i = 0; i < 3; i++) begin
        cm5_r[i] <= c4_r[i][lav_pkg::C_W-1] ? lav_pkg::C_W'(-c4_r[i])
                                            : lav_pkg::C_W'(c4_r[i]);
        cn5_r[i] <= c4_r[i][lav_pkg::C_W-1];
      end
      e5_r <= e4_r; f5_r <= f4_r; z5_r <= z4_r;

      sh6_r <= sh_nxt;
      cm6_r <= cm5_r; cn6_r <= cn5_r;
      e6_r <= e5_r; f6_r <= f5_r;
      z6_r <= z5_r | (cor == '0);

      for (int i = 0; i < 3; i++) begin
        m7_r[i] <= lav_pkg::NM_W'(cm6_r[i] >> sh6_r);
      end
      cn7_r <= cn6_r; e7_r <= e6_r; f7_r <= f6_r; z7_r <= z6_r;
    end
  end

  // ---------------- second normalizer: side vector
  lav_pkg::quot_t q2 [3];
  lav_norm u_norm_side (.clk(clk), .en(en), .mag_i(m7_r), .quot_o(q2));

  lav_pkg::coord_t sb2_e_r [NL][3];
  lav_pkg::rot_t   sb2_f_r [NL][3];
  logic [2:0]      sb2_neg_r [NL];
  logic            sb2_z_r [NL];

  always_ff @(posedge clk) begin
    if (en) begin
      sb2_e_r[0]   <= e7_r;
      sb2_f_r[0]   <= f7_r;
      sb2_neg_r[0] <= cn7_r;
      sb2_z_r[0]   <= z7_r;
      for (int k = 1; k < NL; k++) begin
        sb2_e_r[k]   <= sb2_e_r[k-1];
        sb2_f_r[k]   <= sb2_f_r[k-1];
        sb2_neg_r[k] <= sb2_neg_r[k-1];
        sb2_z_r[k]   <= sb2_z_r[k-1];
      end
    end
  end

  // ---------------- recomputed up, translations, output word
  lav_pkg::coord_t e8_r [3], e9_r [3], e10_r [3];
  lav_pkg::rot_t   l8_r [3], l9_r [3], l10_r [3], l11_r [3], l12_r [3];
  lav_pkg::rot_t   f8_r [3], f9_r [3], f10_r [3], f11_r [3], f12_r [3];
  lav_pkg::rot_t   u10_r [3], u11_r [3], u12_r [3];
  logic            z8_r, z9_r, z10_r, z11_r, z12_r;
  logic signed [lav_pkg::FL_W-1:0] fl9_r [6];
  logic signed [lav_pkg::CP_W-1:0] le9_r [3], fe9_r [3], ue11_r [3];
  logic signed [DW-1:0]            dl10_r, df10_r, dl11_r, df11_r, du12_r;
  lav_pkg::xlat_t                  sx12_r, sz12_r;

  lav_pkg::rot_t  side_r [3], upw_r [3], back_r [3];
  lav_pkg::xlat_t shx_r, shy_r, shz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l8_r[i] <= sb2_neg_r[NL-1][i] ? -lav_pkg::rot_t'(q2[i]) : lav_pkg::rot_t'(q2[i]);
      end
      e8_r <= sb2_e_r[NL-1]; f8_r <= sb2_f_r[NL-1]; z8_r <= sb2_z_r[NL-1];

      fl9_r[0] <= f8_r[1] * l8_r[2];
      fl9_r[1] <= f8_r[2] * l8_r[1];
      fl9_r[2] <= f8_r[2] * l8_r[0];
      fl9_r[3] <= f8_r[0] * l8_r[2];
      fl9_r[4] <= f8_r[0] * l8_r[1];
      fl9_r[5] <= f8_r[1] * l8_r[0];
      for (int j = 0; j < 3; j++) begin
        le9_r[j] <= l8_r[j] * e8_r[j];
        fe9_r[j] <= f8_r[j] * e8_r[j];
      end
      e9_r <= e8_r; l9_r <= l8_r; f9_r <= f8_r; z9_r <= z8_r;

      for (int i = 0; i < 3; i++) begin
        u10_r[i] <= uclamp(DW'(fl9_r[2*i]) - DW'(fl9_r[2*i+1]));
      end
      dl10_r <= DW'(le9_r[0]) + DW'(le9_r[1]) + DW'(le9_r[2]);
      df10_r <= DW'(fe9_r[0]) + DW'(fe9_r[1]) + DW'(fe9_r[2]);
      e10_r <= e9_r; l10_r <= l9_r; f10_r <= f9_r; z10_r <= z9_r;

      for (int j = 0; j < 3; j++) begin
        ue11_r[j] <= u10_r[j] * e10_r[j];
      end
      dl11_r <= dl10_r; df11_r <= df10_r;
      u11_r <= u10_r; l11_r <= l10_r; f11_r <= f10_r; z11_r <= z10_r;

      du12_r <= DW'(ue11_r[0]) + DW'(ue11_r[1]) + DW'(ue11_r[2]);
      sx12_r <= xlate(dl11_r);
      sz12_r <= xlate(df11_r);
      u12_r <= u11_r; l12_r <= l11_r; f12_r <= f11_r; z12_r <= z11_r;

      // degenerate view or up direction gives an all-zero word
      for (int i = 0; i < 3; i++) begin
        side_r[i] <= z12_r ? '0 : l12_r[i];
        upw_r[i]  <= z12_r ? '0 : u12_r[i];
        back_r[i] <= z12_r ? '0 : f12_r[i];
      end
      shx_r <= z12_r ? '0 : sx12_r;
      shy_r <= z12_r ? '0 : xlate(du12_r);
      shz_r <= z12_r ? '0 : sz12_r;
    end
  end

  assign out_tdata = {(8*lav_pkg::OUT_BYTES - lav_pkg::OUT_BITS)'(0),
                      shz_r, shy_r, shx_r,
                      back_r[2], back_r[1], back_r[0],
                      upw_r[2], upw_r[1], upw_r[0],
                      side_r[2], side_r[1], side_r[0]};

endmodule

`default_nettype wire

// ===== rtl/lav_check.sv =====
// port-level checker for the look-at view matrix unit, bound to the top
// uses look_at_view_matrix_unit_macros.svh and lav_pkg
`default_nettype none

`include "look_at_view_matrix_unit_macros.svh"

module lav_check (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [8*lav_pkg::OUT_BYTES-1:0]  out_tdata
);

  logic signed [lav_pkg::ROT_W-1:0] side_x;
  assign side_x = out_tdata[lav_pkg::ROT_W-1:0];

  // held word stays put
  `LAV_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output word changed while stalled")

  // an empty output never blocks the input
  `LAV_IMPLY(a_ready_when_empty, !out_tvalid, in_tready, "input blocked with empty output")

  // a stalled output stalls the input
  `LAV_IMPLY(a_no_take_on_stall, out_tvalid && !out_tready, !in_tready, "input taken while output stalled")

  // the side_x rotation entry is unit scale at most
  `LAV_IMPLY(a_side_range, out_tvalid, (side_x <= 18'sd65536) && (side_x >= -18'sd65536), "side_x out of range")

endmodule

bind look_at_view_matrix_unit lav_check u_lav_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
